@@ design/cal_clk_pkg.sv @@
// ----------------------------------------------------------------------------
// Calendar clock package
// Beat types, register codes, calendar tables and the date arithmetic
// shared by the calendar clock datapath.
// ----------------------------------------------------------------------------
package cal_clk_pkg;

    // calendar base and derived century terms
    localparam int unsigned BASE_YEAR   = 2000;
    localparam int unsigned CENT_BEFORE = (BASE_YEAR - 1) / 100;
    localparam int unsigned CENT_BASE   = BASE_YEAR / 100;
    localparam int unsigned CENT_AFTER  = (BASE_YEAR + 100) / 100;
    localparam int unsigned QUAD_BEFORE = (BASE_YEAR - 1) / 400;
    localparam int unsigned QUAD_BASE   = BASE_YEAR / 400;

    localparam logic [16:0] DAY_SECONDS  = 17'd86400;
    localparam logic [11:0] HOUR_SECONDS = 12'd3600;

    // one and two days in seconds, signed for the countdown fold
    localparam logic signed [18:0] DAY_S  = $signed({2'b00, DAY_SECONDS});
    localparam logic signed [18:0] DAY_S2 = DAY_S + DAY_S;

    // input opcodes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [3:0] CFG_ALARM_YEAR   = 4'd0;
    localparam logic [3:0] CFG_ALARM_MONTH  = 4'd1;
    localparam logic [3:0] CFG_ALARM_DAY    = 4'd2;
    localparam logic [3:0] CFG_ALARM_HOUR   = 4'd3;
    localparam logic [3:0] CFG_ALARM_MINUTE = 4'd4;
    localparam logic [3:0] CFG_ALARM_SECOND = 4'd5;
    localparam logic [3:0] CFG_ALARM_ON     = 4'd6;
    localparam logic [3:0] CFG_ZONE_HOURS   = 4'd7;

    // days before the first of each month, out-of-range months clamp
    localparam logic [8:0] DAYS_BEFORE [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365, 9'd365, 9'd365
    };

    // 3*(m+1)/5 term of the weekday formula
    localparam logic [3:0] MONTH_TERM [16] = '{
        4'd0, 4'd1, 4'd1, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd9, 4'd9
    };

    typedef struct packed {
        logic       opcode;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_day;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
        logic       from_utc;
        logic       late_fix;
    } cal_in_t;

    typedef struct packed {
        logic [6:0]  cur_year;
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [4:0]  cur_hour;
        logic [5:0]  cur_minute;
        logic [5:0]  cur_second;
        logic [2:0]  weekday;
        logic        alarm_full;
        logic        alarm_clock;
        logic [15:0] left_days;
        logic [16:0] left_seconds;
    } cal_out_t;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } cal_time_t;

    // leap test on the full year, years 2000..2127
    function automatic logic is_leap(input logic [6:0] yoff);
        return (yoff[1:0] == 2'd0) && (yoff != 7'd100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] yoff);
        logic [4:0] len;
        case (m)
            4'd2: begin
                len = is_leap(yoff) ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

    // day carry, a month outside 1..12 leaves the date alone
    function automatic cal_time_t next_day(input cal_time_t t);
        cal_time_t r;
        r = t;
        if (t.month >= 4'd1 && t.month <= 4'd12) begin
            if (t.day >= month_len(t.month, t.year)) begin
                r.day = 5'd1;
                if (t.month == 4'd12) begin
                    r.month = 4'd1;
                    r.year  = (t.year >= 7'd99) ? 7'd0 : t.year + 7'd1;
                end else begin
                    r.month = t.month + 4'd1;
                end
            end else begin
                r.day = t.day + 5'd1;
            end
        end
        return r;
    endfunction

    function automatic cal_time_t next_second(input cal_time_t t);
        cal_time_t r;
        r = t;
        if (t.second < 6'd59) begin
            r.second = t.second + 6'd1;
        end else begin
            r.second = 6'd0;
            if (t.minute < 6'd59) begin
                r.minute = t.minute + 6'd1;
            end else begin
                r.minute = 6'd0;
                if (t.hour < 5'd23) begin
                    r.hour = t.hour + 5'd1;
                end else begin
                    r.hour = 5'd0;
                    r = next_day(r);
                end
            end
        end
        return r;
    endfunction

    // x mod 7 by folding octal digits, since 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [15:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]) + 6'(x[15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        return (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

    // weekday on the full year, 1 Monday .. 7 Sunday
    function automatic logic [2:0] weekday_of(input logic [6:0] yoff, input logic [3:0] m,
                                              input logic [4:0] d);
        logic [3:0]  mm;
        logic [11:0] y;
        logic [4:0]  c100;
        logic [2:0]  c400;
        logic [15:0] sum;
        if (m == 4'd1 || m == 4'd2) begin
            mm = m + 4'd12;
            y  = 12'(BASE_YEAR) + 12'(yoff) - 12'd1;
        end else begin
            mm = m;
            y  = 12'(BASE_YEAR) + 12'(yoff);
        end
        c100 = (y < 12'(BASE_YEAR)) ? 5'(CENT_BEFORE) :
               (y < 12'(BASE_YEAR + 100)) ? 5'(CENT_BASE) : 5'(CENT_AFTER);
        c400 = (y < 12'(BASE_YEAR)) ? 3'(QUAD_BEFORE) : 3'(QUAD_BASE);
        sum  = 16'(d) + {11'd0, mm, 1'b0} + 16'(MONTH_TERM[mm]) + 16'(y) + 16'(y[11:2])
             - 16'(c100) + 16'(c400);
        return mod7(sum) + 3'd1;
    endfunction

    // day number from the base date, can be -1 for day zero of january
    function automatic logic signed [16:0] days_of(input logic [6:0] yoff, input logic [3:0] m,
                                                   input logic [4:0] d);
        logic [7:0]  yoff3;
        logic [5:0]  leaps;
        logic [15:0] base;
        logic [15:0] u;
        yoff3 = {1'b0, yoff} + 8'd3;
        leaps = 6'(yoff3[7:2]) - ((yoff > 7'd100) ? 6'd1 : 6'd0);
        base  = 16'(yoff) * 16'd365;
        u     = base + 16'(leaps) + 16'(DAYS_BEFORE[m])
              + (((m > 4'd2) && is_leap(yoff)) ? 16'd1 : 16'd0) + 16'(d);
        return $signed({1'b0, u}) - 17'sd1;
    endfunction

    // seconds into the day, may pass one day for out-of-range hours
    function automatic logic [16:0] tod_of(input logic [4:0] h, input logic [5:0] mi,
                                           input logic [5:0] s);
        return 17'(h) * 17'(HOUR_SECONDS) + 17'(mi) * 17'd60 + 17'(s);
    endfunction

endpackage

@@ design/calendar_clock_with_alarm_top.sv @@
// ----------------------------------------------------------------------------
// Calendar clock with alarm
// Date and time keeper with tick and load beats, weekday, alarm match
// flags and a countdown to the alarm instant.
// ----------------------------------------------------------------------------
//  channel  | ports                          | direction | beat
//  ---------+--------------------------------+-----------+----------------------
//  input    | s_valid s_ready s_data         | in        | tick or load
//  result   | m_valid m_ready m_data         | out       | date, flags, countdown
//  config   | cfg_valid cfg_ready cfg_index  | in        | one alarm/zone register
//           | cfg_data                       |           |
//
//  One beat is accepted every cycle unless a stalled result backs up the stages;
//  the result passes through the calendar state, the day-number stage and the
//  countdown output register. The rate is set by the calendar state update.
//  Reset sets 2000-01-01 00:00:00 and the register defaults; no clearing pass.
//  A stalled result holds in the output register while the two stages
//  behind it keep filling, so up to three beats sit inside during a stall.
module calendar_clock_with_alarm_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cal_clk_pkg::cal_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cal_clk_pkg::cal_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [7:0]            cfg_data
);

    // configuration registers
    logic [6:0] alarm_year_reg;
    logic [3:0] alarm_month_reg;
    logic [4:0] alarm_day_reg;
    logic [4:0] alarm_hour_reg;
    logic [5:0] alarm_minute_reg;
    logic [5:0] alarm_second_reg;
    logic       alarm_on_reg;
    logic [4:0] zone_hours_reg;

    // calendar state, doubles as the first stage payload
    cal_clk_pkg::cal_time_t time_reg;
    cal_clk_pkg::cal_time_t time_next;
    cal_clk_pkg::cal_time_t load_time;
    cal_clk_pkg::cal_time_t zone_time;
    cal_clk_pkg::cal_time_t load_done;
    logic [5:0]             zone_sum;
    logic [5:0]             zone_wrap;

    // pipeline control
    logic st1_valid_reg;
    logic st1_valid_next;
    logic st2_valid_reg;
    logic st2_valid_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic s_fire;
    logic st2_ready;
    logic out_ready;
    logic st2_load;
    logic out_load;

    // second stage payload
    cal_clk_pkg::cal_time_t st2_time_reg;
    logic [2:0]             st2_weekday_reg;
    logic                   st2_full_reg;
    logic                   st2_clock_reg;
    logic signed [16:0]     st2_days_reg;
    logic [16:0]            st2_tod_reg;
    logic                   tod_match;
    logic                   date_match;

    // alarm instant, recomputed from the registers every cycle
    logic signed [16:0] alm_days_reg;
    logic [16:0]        alm_tod_reg;

    // countdown split
    logic signed [18:0] dd;
    logic signed [18:0] sd;
    logic signed [18:0] q;
    logic signed [18:0] r;
    logic signed [18:0] n;

    cal_clk_pkg::cal_out_t out_reg;
    cal_clk_pkg::cal_out_t out_next;

    // handshakes
    assign out_ready = !m_valid_reg || m_ready;
    assign st2_ready = !st2_valid_reg || out_ready;
    assign s_ready   = !st1_valid_reg || st2_ready;
    assign s_fire    = s_valid && s_ready;
    assign st2_load  = st1_valid_reg && st2_ready;
    assign out_load  = st2_valid_reg && out_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_year_reg   <= 7'd0;
            alarm_month_reg  <= 4'd1;
            alarm_day_reg    <= 5'd1;
            alarm_hour_reg   <= 5'd0;
            alarm_minute_reg <= 6'd0;
            alarm_second_reg <= 6'd0;
            alarm_on_reg     <= 1'b0;
            zone_hours_reg   <= 5'd8;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cal_clk_pkg::CFG_ALARM_YEAR:   alarm_year_reg   <= cfg_data[6:0];
                cal_clk_pkg::CFG_ALARM_MONTH:  alarm_month_reg  <= cfg_data[3:0];
                cal_clk_pkg::CFG_ALARM_DAY:    alarm_day_reg    <= cfg_data[4:0];
                cal_clk_pkg::CFG_ALARM_HOUR:   alarm_hour_reg   <= cfg_data[4:0];
                cal_clk_pkg::CFG_ALARM_MINUTE: alarm_minute_reg <= cfg_data[5:0];
                cal_clk_pkg::CFG_ALARM_SECOND: alarm_second_reg <= cfg_data[5:0];
                cal_clk_pkg::CFG_ALARM_ON:     alarm_on_reg     <= cfg_data[0];
                cal_clk_pkg::CFG_ZONE_HOURS:   zone_hours_reg   <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // load path: zone offset with day carry, then optional extra second
    always_comb begin
        load_time.year   = s_data.load_year;
        load_time.month  = s_data.load_month;
        load_time.day    = s_data.load_day;
        load_time.hour   = s_data.load_hour;
        load_time.minute = s_data.load_minute;
        load_time.second = s_data.load_second;
        zone_sum  = 6'(s_data.load_hour) + 6'(zone_hours_reg);
        zone_wrap = zone_sum - 6'd24;
        zone_time = load_time;
        if (s_data.from_utc) begin
            if (zone_sum >= 6'd24) begin
                zone_time      = cal_clk_pkg::next_day(load_time);
                zone_time.hour = zone_wrap[4:0];
            end else begin
                zone_time.hour = zone_sum[4:0];
            end
        end
        load_done = s_data.late_fix ? cal_clk_pkg::next_second(zone_time) : zone_time;
    end

    // calendar state update
    always_comb begin
        time_next = time_reg;
        if (s_fire) begin
            if (s_data.opcode == cal_clk_pkg::OP_LOAD) begin
                time_next = load_done;
            end else begin
                time_next = cal_clk_pkg::next_second(time_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '{year: 7'd0, month: 4'd1, day: 5'd1,
                          hour: 5'd0, minute: 6'd0, second: 6'd0};
        end else begin
            time_reg <= time_next;
        end
    end

    // stage valid bits
    always_comb begin
        st1_valid_next = s_fire ? 1'b1 : (st2_ready ? 1'b0 : st1_valid_reg);
        st2_valid_next = st2_ready ? st1_valid_reg : st2_valid_reg;
        m_valid_next   = out_ready ? st2_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            st2_valid_reg <= st2_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // alarm instant in day number and time of day
    always_ff @(posedge aclk) begin
        alm_days_reg <= cal_clk_pkg::days_of(alarm_year_reg, alarm_month_reg, alarm_day_reg);
        alm_tod_reg  <= cal_clk_pkg::tod_of(alarm_hour_reg, alarm_minute_reg, alarm_second_reg);
    end

    // stage two: weekday, match flags, current day number and time of day
    assign tod_match  = (alarm_hour_reg == time_reg.hour) &&
                        (alarm_minute_reg == time_reg.minute) &&
                        (alarm_second_reg == time_reg.second);
    assign date_match = (alarm_year_reg == time_reg.year) &&
                        (alarm_month_reg == time_reg.month) &&
                        (alarm_day_reg == time_reg.day);

    always_ff @(posedge aclk) begin
        if (st2_load) begin
            st2_time_reg    <= time_reg;
            st2_weekday_reg <= cal_clk_pkg::weekday_of(time_reg.year, time_reg.month,
                                                       time_reg.day);
            st2_clock_reg   <= alarm_on_reg && tod_match;
            st2_full_reg    <= alarm_on_reg && tod_match && date_match;
            st2_days_reg    <= cal_clk_pkg::days_of(time_reg.year, time_reg.month,
                                                    time_reg.day);
            st2_tod_reg     <= cal_clk_pkg::tod_of(time_reg.hour, time_reg.minute,
                                                   time_reg.second);
        end
    end

    // countdown: fold the time-of-day difference into [0, one day)
    always_comb begin
        dd = $signed({{2{alm_days_reg[16]}}, alm_days_reg})
           - $signed({{2{st2_days_reg[16]}}, st2_days_reg});
        sd = $signed({2'b00, alm_tod_reg}) - $signed({2'b00, st2_tod_reg});
        if (sd < -cal_clk_pkg::DAY_S) begin
            q = -19'sd2;
            r = sd + cal_clk_pkg::DAY_S2;
        end else if (sd < 19'sd0) begin
            q = -19'sd1;
            r = sd + cal_clk_pkg::DAY_S;
        end else if (sd < cal_clk_pkg::DAY_S) begin
            q = 19'sd0;
            r = sd;
        end else begin
            q = 19'sd1;
            r = sd - cal_clk_pkg::DAY_S;
        end
        n = dd + q;

        out_next.cur_year    = st2_time_reg.year;
        out_next.cur_month   = st2_time_reg.month;
        out_next.cur_day     = st2_time_reg.day;
        out_next.cur_hour    = st2_time_reg.hour;
        out_next.cur_minute  = st2_time_reg.minute;
        out_next.cur_second  = st2_time_reg.second;
        out_next.weekday     = st2_weekday_reg;
        out_next.alarm_full  = st2_full_reg;
        out_next.alarm_clock = st2_clock_reg;
        if (n > 19'sd0 || (n == 19'sd0 && r != 19'sd0)) begin
            out_next.left_days    = n[15:0];
            out_next.left_seconds = r[16:0];
        end else begin
            out_next.left_days    = 16'd0;
            out_next.left_seconds = 17'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    // checks
    a_st1_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> st1_valid_reg)
        else $error("accepted beat did not enter the first stage");

    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.alarm_full) |->
        (m_data.left_days == 16'd0 && m_data.left_seconds == 17'd0))
        else $error("full alarm match with nonzero countdown");

    a_clock_sec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.alarm_clock) |-> (m_data.left_seconds == 17'd0))
        else $error("time-of-day match with leftover seconds");

    a_sec_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.left_seconds < cal_clk_pkg::DAY_SECONDS))
        else $error("countdown seconds reach a full day");

    a_wday: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.weekday != 3'd0))
        else $error("weekday out of range");

endmodule

@@ tb/cal_clk_checker.sv @@
// ----------------------------------------------------------------------------
// Calendar clock result checker
// Watches the input, result and config channels of the calendar clock,
// keeps its own copy of the clock and alarm registers, predicts one result
// beat per accepted input beat and compares every result field in order.
// ----------------------------------------------------------------------------
module cal_clk_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  cal_clk_pkg::cal_in_t  s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  cal_clk_pkg::cal_out_t m_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    output int                    failures,
    output int                    pending
);

    // days before the first of each month, months past december count a full year
    localparam int MONTH_START [16] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365, 365, 365
    };
    localparam longint SECONDS_PER_DAY = 24 * 60 * 60;

    cal_clk_pkg::cal_time_t clock_now;
    cal_clk_pkg::cal_time_t alarm_at;
    logic                   alarm_armed;
    logic [4:0]             zone_offset;
    cal_clk_pkg::cal_out_t  reading_q [$];
    cal_clk_pkg::cal_out_t  want;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic bit leap_full_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input logic [3:0] m, input logic [6:0] yoff);
        if (m == 4'd2) begin
            return leap_full_year(cal_clk_pkg::BASE_YEAR + yoff) ? 29 : 28;
        end
        if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            return 30;
        end
        return 31;
    endfunction

    // day carry, months outside 1..12 keep the date as it is
    function automatic cal_clk_pkg::cal_time_t roll_day(input cal_clk_pkg::cal_time_t t);
        if (t.month < 4'd1 || t.month > 4'd12) begin
            return t;
        end
        if (t.day >= days_in_month(t.month, t.year)) begin
            t.day = 5'd1;
            if (t.month == 4'd12) begin
                t.month = 4'd1;
                t.year  = (t.year >= 7'd99) ? 7'd0 : t.year + 7'd1;
            end else begin
                t.month = t.month + 4'd1;
            end
        end else begin
            t.day = t.day + 5'd1;
        end
        return t;
    endfunction

    function automatic cal_clk_pkg::cal_time_t roll_second(input cal_clk_pkg::cal_time_t t);
        if (t.second < 6'd59) begin
            t.second = t.second + 6'd1;
            return t;
        end
        t.second = 6'd0;
        if (t.minute < 6'd59) begin
            t.minute = t.minute + 6'd1;
            return t;
        end
        t.minute = 6'd0;
        if (t.hour < 5'd23) begin
            t.hour = t.hour + 5'd1;
            return t;
        end
        t.hour = 5'd0;
        return roll_day(t);
    endfunction

    // weekday on the full year, january and february belong to the year before
    function automatic logic [2:0] day_of_week(input cal_clk_pkg::cal_time_t t);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        y = cal_clk_pkg::BASE_YEAR + t.year;
        m = t.month;
        d = t.day;
        if (m == 1 || m == 2) begin
            m = m + 12;
            y = y - 1;
        end
        return 3'((d + 2 * m + 3 * (m + 1) / 5 + y + y / 4 - y / 100 + y / 400) % 7 + 1);
    endfunction

    // seconds since the base date, fields taken as stored
    function automatic longint seconds_from_base(input cal_clk_pkg::cal_time_t t);
        longint days;
        int     i;
        days = 0;
        for (i = 0; i < int'(t.year); i++) begin
            days += leap_full_year(cal_clk_pkg::BASE_YEAR + i) ? 366 : 365;
        end
        days += MONTH_START[t.month];
        if (t.month > 4'd2 && leap_full_year(cal_clk_pkg::BASE_YEAR + t.year)) begin
            days += 1;
        end
        days += longint'(t.day) - 1;
        return days * SECONDS_PER_DAY + longint'(t.hour) * 3600
             + longint'(t.minute) * 60 + longint'(t.second);
    endfunction

    // apply one input beat to the clock copy and form the result beat
    function automatic cal_clk_pkg::cal_out_t next_reading(input cal_clk_pkg::cal_in_t b);
        cal_clk_pkg::cal_out_t r;
        int                    hsum;
        logic                  tod_eq;
        logic                  date_eq;
        longint                gap;
        if (b.opcode == cal_clk_pkg::OP_TICK) begin
            clock_now = roll_second(clock_now);
        end else begin
            clock_now.year   = b.load_year;
            clock_now.month  = b.load_month;
            clock_now.day    = b.load_day;
            clock_now.hour   = b.load_hour;
            clock_now.minute = b.load_minute;
            clock_now.second = b.load_second;
            if (b.from_utc) begin
                hsum = int'(clock_now.hour) + int'(zone_offset);
                if (hsum >= 24) begin
                    hsum = hsum - 24;
                    clock_now = roll_day(clock_now);
                end
                clock_now.hour = 5'(hsum);
            end
            if (b.late_fix) begin
                clock_now = roll_second(clock_now);
            end
        end

        tod_eq  = (alarm_at.hour == clock_now.hour) && (alarm_at.minute == clock_now.minute)
               && (alarm_at.second == clock_now.second);
        date_eq = (alarm_at.year == clock_now.year) && (alarm_at.month == clock_now.month)
               && (alarm_at.day == clock_now.day);
        gap = seconds_from_base(alarm_at) - seconds_from_base(clock_now);

        r.cur_year    = clock_now.year;
        r.cur_month   = clock_now.month;
        r.cur_day     = clock_now.day;
        r.cur_hour    = clock_now.hour;
        r.cur_minute  = clock_now.minute;
        r.cur_second  = clock_now.second;
        r.weekday     = day_of_week(clock_now);
        r.alarm_full  = alarm_armed && tod_eq && date_eq;
        r.alarm_clock = alarm_armed && tod_eq;
        if (gap > 0) begin
            r.left_days    = 16'(gap / SECONDS_PER_DAY);
            r.left_seconds = 17'(gap % SECONDS_PER_DAY);
        end else begin
            r.left_days    = '0;
            r.left_seconds = '0;
        end
        return r;
    endfunction

    task automatic check_field(input string name, input longint exp_val, input longint act_val);
        if (exp_val != act_val) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
            failures++;
        end
    endtask

    // track the channels, oldest prediction first
    always @(posedge aclk) begin
        if (!aresetn) begin
            clock_now   = '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
            alarm_at    = '{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0};
            alarm_armed = 1'b0;
            zone_offset = 5'd8;
            reading_q.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                if (reading_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual %h",
                             $time, m_data);
                    failures++;
                end else begin
                    want = reading_q.pop_front();
                    check_field("cur_year", want.cur_year, m_data.cur_year);
                    check_field("cur_month", want.cur_month, m_data.cur_month);
                    check_field("cur_day", want.cur_day, m_data.cur_day);
                    check_field("cur_hour", want.cur_hour, m_data.cur_hour);
                    check_field("cur_minute", want.cur_minute, m_data.cur_minute);
                    check_field("cur_second", want.cur_second, m_data.cur_second);
                    check_field("weekday", want.weekday, m_data.weekday);
                    check_field("alarm_full", want.alarm_full, m_data.alarm_full);
                    check_field("alarm_clock", want.alarm_clock, m_data.alarm_clock);
                    check_field("left_days", want.left_days, m_data.left_days);
                    check_field("left_seconds", want.left_seconds, m_data.left_seconds);
                end
            end

            // register writes, data above each field's width is dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cal_clk_pkg::CFG_ALARM_YEAR: begin
                        alarm_at.year = cfg_data[6:0];
                    end
                    cal_clk_pkg::CFG_ALARM_MONTH: begin
                        alarm_at.month = cfg_data[3:0];
                    end
                    cal_clk_pkg::CFG_ALARM_DAY: begin
                        alarm_at.day = cfg_data[4:0];
                    end
                    cal_clk_pkg::CFG_ALARM_HOUR: begin
                        alarm_at.hour = cfg_data[4:0];
                    end
                    cal_clk_pkg::CFG_ALARM_MINUTE: begin
                        alarm_at.minute = cfg_data[5:0];
                    end
                    cal_clk_pkg::CFG_ALARM_SECOND: begin
                        alarm_at.second = cfg_data[5:0];
                    end
                    cal_clk_pkg::CFG_ALARM_ON: begin
                        alarm_armed = cfg_data[0];
                    end
                    cal_clk_pkg::CFG_ZONE_HOURS: begin
                        zone_offset = cfg_data[4:0];
                    end
                    default: begin
                    end
                endcase
            end

            // input beat adds one prediction
            if (s_valid && s_ready) begin
                reading_q.push_back(next_reading(s_data));
            end
        end
        pending = reading_q.size();
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Calendar clock regression bench
// Drives tick and load beats and alarm/zone register writes into the
// calendar clock: a directed pass over rollovers, leap years, zone carry,
// odd field values and alarm hits, then random phases with sender gaps,
// receiver stalls and one long receiver hold-off. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEMS_PER_PHASE = 310;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD       = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    cal_clk_pkg::cal_in_t  s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    cal_clk_pkg::cal_out_t m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [3:0]            cfg_index = cal_clk_pkg::CFG_ALARM_YEAR;
    logic [7:0]            cfg_data  = '0;

    int failures;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int hold_seq       = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    // alarm as last written, used to aim loads near it
    cal_clk_pkg::cal_time_t alarm_goal;

    calendar_clock_with_alarm_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cal_clk_checker i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // result ready: random stalls, plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("calendar_clock_with_alarm_top regression: fail");
        $finish;
    end

    function automatic cal_clk_pkg::cal_in_t tick_beat();
        cal_clk_pkg::cal_in_t b;
        b = cal_clk_pkg::cal_in_t'({$urandom(), $urandom()});
        b.opcode = cal_clk_pkg::OP_TICK;
        return b;
    endfunction

    function automatic cal_clk_pkg::cal_in_t load_beat(input logic [6:0] yr,
                                                       input logic [3:0] mo,
                                                       input logic [4:0] dy,
                                                       input logic [4:0] hr,
                                                       input logic [5:0] mi,
                                                       input logic [5:0] se,
                                                       input logic utc, input logic fix);
        cal_clk_pkg::cal_in_t b;
        b.opcode      = cal_clk_pkg::OP_LOAD;
        b.load_year   = yr;
        b.load_month  = mo;
        b.load_day    = dy;
        b.load_hour   = hr;
        b.load_minute = mi;
        b.load_second = se;
        b.from_utc    = utc;
        b.late_fix    = fix;
        return b;
    endfunction

    // mostly ticks and loads just short of a rollover or the alarm, some raw noise
    function automatic cal_clk_pkg::cal_in_t random_beat();
        cal_clk_pkg::cal_in_t b;
        int unsigned          pick;
        b    = cal_clk_pkg::cal_in_t'({$urandom(), $urandom()});
        pick = $urandom_range(99);
        if (pick < 60) begin
            b.opcode = cal_clk_pkg::OP_TICK;
        end else if (pick < 85) begin
            b.opcode      = cal_clk_pkg::OP_LOAD;
            b.load_year   = ($urandom_range(3) == 0) ? 7'd99 : 7'($urandom_range(99));
            b.load_month  = 4'($urandom_range(12, 1));
            b.load_day    = $urandom_range(1) ? 5'($urandom_range(31, 27))
                                              : 5'($urandom_range(31, 1));
            b.load_hour   = $urandom_range(1) ? 5'd23 : 5'($urandom_range(23));
            b.load_minute = $urandom_range(1) ? 6'd59 : 6'($urandom_range(59));
            b.load_second = 6'($urandom_range(59, 50));
        end else if (pick < 93) begin
            b.opcode      = cal_clk_pkg::OP_LOAD;
            b.load_year   = alarm_goal.year;
            b.load_month  = alarm_goal.month;
            b.load_day    = ($urandom_range(3) == 0) ? 5'($urandom_range(28, 1))
                                                     : alarm_goal.day;
            b.load_hour   = alarm_goal.hour;
            b.load_minute = alarm_goal.minute;
            b.load_second = (alarm_goal.second >= 6'd3) ?
                            6'(alarm_goal.second - $urandom_range(3)) : alarm_goal.second;
            b.from_utc    = 1'b0;
        end
        return b;
    endfunction

    // one input beat, valid held until accepted and left high for the next
    task automatic send_beat(input cal_clk_pkg::cal_in_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic program_alarm(input logic [7:0] yr, input logic [7:0] mo,
                                 input logic [7:0] dy, input logic [7:0] hr,
                                 input logic [7:0] mi, input logic [7:0] se,
                                 input logic [7:0] on, input logic [7:0] zone);
        write_reg(cal_clk_pkg::CFG_ALARM_YEAR, yr);
        write_reg(cal_clk_pkg::CFG_ALARM_MONTH, mo);
        write_reg(cal_clk_pkg::CFG_ALARM_DAY, dy);
        write_reg(cal_clk_pkg::CFG_ALARM_HOUR, hr);
        write_reg(cal_clk_pkg::CFG_ALARM_MINUTE, mi);
        write_reg(cal_clk_pkg::CFG_ALARM_SECOND, se);
        write_reg(cal_clk_pkg::CFG_ALARM_ON, on);
        write_reg(cal_clk_pkg::CFG_ZONE_HOURS, zone);
        cfg_valid <= 1'b0;
        alarm_goal = '{yr[6:0], mo[3:0], dy[4:0], hr[4:0], mi[5:0], se[5:0]};
    endtask

    // all predictions matched, then let the pipeline settle
    task automatic wait_idle();
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit squeeze);
        int n;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long receiver hold-off while beats keep coming
            if (squeeze && n == 40) begin
                hold_len = LONG_HOLD;
                hold_seq++;
            end
            send_beat(random_beat());
        end
        s_valid <= 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed pass, no idling
        program_alarm(8'd30, 8'd6, 8'd15, 8'd12, 8'd34, 8'd56, 8'd1, 8'd8);
        send_beat(tick_beat());
        // century wrap
        send_beat(load_beat(7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, 1'b0));
        send_beat(tick_beat());
        // february end, leap and non-leap, late fix carries
        send_beat(load_beat(7'd0, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0, 1'b1));
        send_beat(load_beat(7'd1, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0, 1'b1));
        send_beat(load_beat(7'd100, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59, 1'b0, 1'b1));
        // december to january
        send_beat(load_beat(7'd24, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, 1'b0));
        send_beat(tick_beat());
        // zone carry into the next day, then into the next year with late fix
        send_beat(load_beat(7'd23, 4'd6, 5'd30, 5'd20, 6'd0, 6'd0, 1'b1, 1'b0));
        send_beat(load_beat(7'd23, 4'd12, 5'd31, 5'd16, 6'd0, 6'd0, 1'b1, 1'b1));
        // invalid months hold the date on a day carry
        send_beat(load_beat(7'd10, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59, 1'b0, 1'b0));
        send_beat(tick_beat());
        send_beat(load_beat(7'd10, 4'd13, 5'd5, 5'd23, 6'd59, 6'd59, 1'b1, 1'b1));
        send_beat(load_beat(7'd10, 4'd15, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0));
        // hour beyond 23 on a tick
        send_beat(load_beat(7'd5, 4'd3, 5'd10, 5'd31, 6'd59, 6'd59, 1'b0, 1'b0));
        send_beat(tick_beat());
        // all ones and all zeros
        send_beat(load_beat(7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63, 1'b1, 1'b1));
        send_beat(load_beat(7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 1'b0, 1'b0));
        // same time of day three days early: whole days, zero seconds
        send_beat(load_beat(7'd30, 4'd6, 5'd12, 5'd12, 6'd34, 6'd56, 1'b0, 1'b0));
        // tick onto the alarm, then past it
        send_beat(load_beat(7'd30, 4'd6, 5'd15, 5'd12, 6'd34, 6'd55, 1'b0, 1'b0));
        send_beat(tick_beat());
        send_beat(tick_beat());
        // time of day only match on a later date
        send_beat(load_beat(7'd31, 4'd1, 5'd1, 5'd12, 6'd34, 6'd56, 1'b0, 1'b0));
        s_valid <= 1'b0;
        wait_idle();

        // random alarm, no idling, long hold-off
        program_alarm(8'($urandom_range(99)), 8'($urandom_range(12, 1)),
                      8'($urandom_range(28, 1)), 8'($urandom_range(23)),
                      8'($urandom_range(59)), 8'($urandom_range(59)), 8'd1,
                      8'($urandom_range(23)));
        run_phase(0, 0, 1'b1);

        // lowest settings, sender gaps
        program_alarm(8'd0, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0);
        run_phase(53, 0, 1'b0);

        // every data bit set, receiver stalls
        program_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_phase(0, 53, 1'b0);

        // last legal instant, flags disabled, both sides idling
        program_alarm(8'd99, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 8'd0, 8'd23);
        run_phase(26, 26, 1'b0);

        if (failures == 0) begin
            $display("calendar_clock_with_alarm_top regression: pass");
        end else begin
            $display("calendar_clock_with_alarm_top regression: fail");
        end
        $finish;
    end

endmodule
